FILE: hdl/rfp_pkg.sv
// Shared types and constants for the RESP frame parser.
// Depends on nothing; imported by resp_frame_parser.
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int LenBitsDef = 31;  // default width of the decimal header accumulator
  localparam int BulkW      = 31;  // max_bulk_length and payload counter width
  localparam int CountW     = 21;  // max_array_count and element counter width
  localparam int CfgDataW   = 31;  // widest configuration register
  localparam int CfgIdxW    = 2;
  localparam int HdrValW    = 32;

  localparam logic [BulkW-1:0]  MaxBulkRst  = BulkW'(536870912);
  localparam logic [CountW-1:0] MaxCountRst = CountW'(1048576);

  localparam logic [CfgIdxW-1:0] CfgMaxBulk   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChkTrail  = 2'd2;

  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [HdrValW-1:0] HdrNull = '1;  // -1 for a null bulk string

  typedef enum logic [3:0] {
    PhAwait  = 4'd0,
    PhLine   = 4'd1,
    PhLineLf = 4'd2,
    PhHdr    = 4'd3,
    PhHdrLf  = 4'd4,
    PhPay    = 4'd5,
    PhTrCr   = 4'd6,
    PhTrLf   = 4'd7,
    PhResync = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    EvBusy = 2'd0,
    EvElem = 2'd1,
    EvMsg  = 2'd2,
    EvErr  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    KindSimple = 3'd0,
    KindError  = 3'd1,
    KindInt    = 3'd2,
    KindBulk   = 3'd3,
    KindArray  = 3'd4
  } kind_e;

endpackage

FILE: hdl/resp_frame_parser.sv
// RESP2 message framer, top level: one stream word in, one event word out.
// Depends on rfp_pkg for types, character codes and register indexes.
`timescale 1ns / 1ps

// Feed the received RESP2 stream one byte per word; every input word yields
// exactly one result word carrying an event (in progress, element done,
// message done, error), the content byte where the byte is line or payload
// content, and the decoded length or count when a $ or * header line ends.
// Line types (+ - :) end at CR LF, bulk strings ($) take a strict decimal
// length then that many payload bytes and a CR LF trailer (-1 is null), and
// arrays (*) take a count followed by that many non-nested elements. After
// an error the parser skips bytes until a type byte; restart on a word drops
// any partial message and takes that byte as a type byte. Throughput is one
// byte per clock and each result is registered: the whole state update for a
// byte is one shallow pass from the parser state to the result register, and
// the input stays ready while the result register is empty or being drained.
// Write configuration only while no word is in flight.
module resp_frame_parser import rfp_pkg::*; #(
  parameter int LEN_BITS = LenBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                restart_i,
  // result stream
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          event_res_o,
  output logic                content_valid_o,
  output logic [7:0]          content_byte_o,
  output logic                header_done_o,
  output logic signed [HdrValW-1:0] header_value_o,
  output logic [2:0]          element_kind_o
);

  // widths for comparing the accumulator against the limit registers
  localparam int CmpW = (LEN_BITS > BulkW) ? LEN_BITS : BulkW;
  localparam int HvW  = (LEN_BITS > HdrValW) ? LEN_BITS : HdrValW;
  localparam int MulW = LEN_BITS + 4;

  // configuration
  logic [BulkW-1:0]  max_bulk_q;
  logic [CountW-1:0] max_count_q;
  logic              chk_trail_q;

  // parser state
  phase_e              phase_q, phase_d;
  kind_e               kind_q, kind_d;
  logic                in_arr_q, in_arr_d;
  logic [CountW-1:0]   elems_q, elems_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                seen_q, seen_d;
  logic [BulkW-1:0]    pay_q, pay_d;

  // result register
  logic               out_valid_q;
  event_e             ev_q, ev_d;
  logic               cv_q, cv_d;
  logic [7:0]         cb_q;
  logic               hd_q, hd_d;
  logic [HdrValW-1:0] hv_q, hv_d;

  logic in_fire;

  // helpers derived from the current byte and state
  logic                arr_live;      // array context after restart is applied
  logic                tt_ok;
  kind_e               tt_kind;
  logic [CountW-1:0]   elems_dec;
  logic                is_digit;
  logic [MulW-1:0]     acc_next;
  logic                acc_ovf;
  logic [CmpW-1:0]     acc_cmp;
  logic [HvW-1:0]      acc_hv;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bulk_q  <= MaxBulkRst;
      max_count_q <= MaxCountRst;
      chk_trail_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxBulk:  max_bulk_q  <= cfg_data_i[BulkW-1:0];
        CfgMaxCount: max_count_q <= cfg_data_i[CountW-1:0];
        CfgChkTrail: chk_trail_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign arr_live  = in_arr_q && !restart_i;
  assign elems_dec = elems_q - CountW'(1);
  assign is_digit  = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
  // acc * 10 + digit, kept four bits wider to catch overflow
  assign acc_next  = (MulW'(acc_q) << 3) + (MulW'(acc_q) << 1)
                   + MulW'(data_byte_i[3:0]);
  assign acc_ovf   = acc_next[MulW-1:LEN_BITS] != '0;
  assign acc_cmp   = CmpW'(acc_q);
  assign acc_hv    = HvW'(acc_q);

  // type byte decode; a star inside an array is rejected
  always_comb begin
    tt_ok   = 1'b1;
    tt_kind = KindSimple;
    priority if (data_byte_i == ChPlus)   tt_kind = KindSimple;
    else if (data_byte_i == ChMinus)      tt_kind = KindError;
    else if (data_byte_i == ChColon)      tt_kind = KindInt;
    else if (data_byte_i == ChDollar)     tt_kind = KindBulk;
    else if (data_byte_i == ChStar && !arr_live) tt_kind = KindArray;
    else                                  tt_ok = 1'b0;
  end

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    in_arr_d = in_arr_q;
    elems_d  = elems_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    pay_d    = pay_q;
    ev_d     = EvBusy;
    cv_d     = 1'b0;
    hd_d     = 1'b0;
    hv_d     = '0;

    // restart drops the partial message and array context
    if (restart_i) begin
      in_arr_d = 1'b0;
      elems_d  = '0;
      phase_d  = PhAwait;
    end

    unique case (restart_i ? PhAwait : phase_q)
      PhAwait, PhResync: begin
        if (tt_ok) begin
          kind_d  = tt_kind;
          phase_d = (tt_kind == KindBulk || tt_kind == KindArray) ? PhHdr : PhLine;
          acc_d   = '0;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
        end else if (restart_i || phase_q == PhAwait) begin
          // unknown type byte: an error; while resyncing it is skipped
          kind_d   = KindSimple;
          ev_d     = EvErr;
          phase_d  = PhResync;
          in_arr_d = 1'b0;
          elems_d  = '0;
        end
      end
      PhLine: begin
        if (data_byte_i == ChCr) phase_d = PhLineLf;
        else                     cv_d    = 1'b1;
      end
      PhHdr: begin
        if (is_digit) begin
          if (acc_ovf) begin
            ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
          end else begin
            acc_d  = acc_next[LEN_BITS-1:0];
            seen_d = 1'b1;
          end
        end else if (data_byte_i == ChMinus && !seen_q && !neg_q) begin
          neg_d = 1'b1;
        end else if (data_byte_i == ChCr && seen_q) begin
          phase_d = PhHdrLf;
        end else begin
          ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
        end
      end
      PhHdrLf: begin
        if (data_byte_i != ChLf) begin
          ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
        end else if (kind_q == KindBulk) begin
          if (neg_q) begin
            if (acc_q == LEN_BITS'(1)) begin
              // null bulk string ends the element here
              hd_d    = 1'b1;
              hv_d    = HdrNull;
              phase_d = PhAwait;
              ev_d    = EvMsg;
              if (in_arr_q) begin
                elems_d = elems_dec;
                if (elems_dec == '0) in_arr_d = 1'b0;
                else                 ev_d     = EvElem;
              end
            end else begin
              ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
            end
          end else if (acc_cmp > CmpW'(max_bulk_q)) begin
            ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
          end else begin
            hd_d    = 1'b1;
            hv_d    = acc_hv[HdrValW-1:0];
            pay_d   = BulkW'(acc_q);
            phase_d = (acc_q == '0) ? PhTrCr : PhPay;
          end
        end else begin
          if (neg_q || acc_q == '0) begin
            // negative or zero count: empty array
            hd_d    = 1'b1;
            phase_d = PhAwait;
            ev_d    = EvMsg;
          end else if (acc_cmp > CmpW'(max_count_q)) begin
            ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
          end else begin
            hd_d     = 1'b1;
            hv_d     = acc_hv[HdrValW-1:0];
            in_arr_d = 1'b1;
            elems_d  = CountW'(acc_q);
            phase_d  = PhAwait;
          end
        end
      end
      PhPay: begin
        cv_d  = 1'b1;
        pay_d = pay_q - BulkW'(1);
        if (pay_q == BulkW'(1)) phase_d = PhTrCr;
      end
      PhTrCr: begin
        if (chk_trail_q && data_byte_i != ChCr) begin
          ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
        end else begin
          phase_d = PhTrLf;
        end
      end
      PhLineLf, PhTrLf: begin
        if (data_byte_i != ChLf && (phase_q == PhLineLf || chk_trail_q)) begin
          ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
        end else begin
          // element done: count it down inside an array
          phase_d = PhAwait;
          ev_d    = EvMsg;
          if (in_arr_q) begin
            elems_d = elems_dec;
            if (elems_dec == '0) in_arr_d = 1'b0;
            else                 ev_d     = EvElem;
          end
        end
      end
      default: begin
        ev_d = EvErr; phase_d = PhResync; in_arr_d = 1'b0; elems_d = '0;
      end
    endcase
  end

  // advance parser state on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhAwait;
      kind_q   <= KindSimple;
      in_arr_q <= 1'b0;
      elems_q  <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      seen_q   <= 1'b0;
      pay_q    <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      in_arr_q <= in_arr_d;
      elems_q  <= elems_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      seen_q   <= seen_d;
      pay_q    <= pay_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload: load with each accepted word, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q <= ev_d;
      cv_q <= cv_d;
      cb_q <= cv_d ? data_byte_i : 8'h00;
      hd_q <= hd_d;
      hv_q <= hv_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign content_valid_o = cv_q;
  assign content_byte_o  = cb_q;
  assign header_done_o   = hd_q;
  assign header_value_o  = hv_q;
  assign element_kind_o  = kind_q;

endmodule

FILE: sim/tb_resp_frame_parser.sv
// Self-checking testbench for resp_frame_parser: directed RESP2 frames, then random traffic.
// Depends on rfp_pkg and resp_frame_parser; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_resp_frame_parser;
  import rfp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam longint unsigned HdrMagMax = (64'd1 << LenBitsDef) - 64'd1;
  // The register map leaves index 3 unused; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // One expected result word, field for field as the block presents it.
  typedef struct packed {
    event_e               event_res;
    logic                 content_valid;
    logic [7:0]           content_byte;
    logic                 header_done;
    logic [HdrValW-1:0]   header_value;
    kind_e                element_kind;
  } frame_res_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          event_res_o;
  logic                content_valid_o;
  logic [7:0]          content_byte_o;
  logic                header_done_o;
  logic signed [HdrValW-1:0] header_value_o;
  logic [2:0]          element_kind_o;

  // Framer predictor state and its copy of the configuration registers.
  phase_e              prs_phase     = PhAwait;
  kind_e               prs_kind      = KindSimple;
  logic                in_array      = 1'b0;
  logic [CountW-1:0]   elems_left    = '0;
  longint unsigned     hdr_mag       = 0;
  logic                hdr_neg       = 1'b0;
  logic                hdr_digit     = 1'b0;
  logic [BulkW-1:0]    payload_left  = '0;
  logic [BulkW-1:0]    lim_bulk      = MaxBulkRst;
  logic [CountW-1:0]   lim_count     = MaxCountRst;
  logic                trailer_check = 1'b1;

  frame_res_t events_due[$];   // framing events still owed by the block, oldest first
  frame_res_t want_res;
  bit         dropped_byte;    // last predicted word was skipped while resyncing
  bit         restart_next = 1'b0;
  int         counted_bytes = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         noise_pct = 0;

  always #4 clk_i = ~clk_i;

  resp_frame_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .content_valid_o(content_valid_o),
    .content_byte_o (content_byte_o),
    .header_done_o  (header_done_o),
    .header_value_o (header_value_o),
    .element_kind_o (element_kind_o)
  );

  // ---------------------------------------------------------------------------
  // Framer predictor
  // ---------------------------------------------------------------------------

  // Drop to resync: any array context is lost with the error.
  function automatic event_e enter_resync();
    prs_phase  = PhResync;
    in_array   = 1'b0;
    elems_left = '0;
    return EvErr;
  endfunction

  // Close a line or bulk element; inside an array only the last one ends the message.
  function automatic event_e close_element();
    prs_phase = PhAwait;
    if (in_array) begin
      elems_left = elems_left - 1'b1;
      if (elems_left == '0) begin
        in_array = 1'b0;
        return EvMsg;
      end
      return EvElem;
    end
    return EvMsg;
  endfunction

  // Take a type byte; a star is refused inside an array (no nesting).
  function automatic bit open_element(input logic [7:0] b);
    kind_e k;
    case (b)
      ChPlus:   k = KindSimple;
      ChMinus:  k = KindError;
      ChColon:  k = KindInt;
      ChDollar: k = KindBulk;
      ChStar: begin
        if (in_array) return 1'b0;
        k = KindArray;
      end
      default: return 1'b0;
    endcase
    prs_kind  = k;
    prs_phase = (k == KindBulk || k == KindArray) ? PhHdr : PhLine;
    hdr_mag   = 0;
    hdr_neg   = 1'b0;
    hdr_digit = 1'b0;
    return 1'b1;
  endfunction

  // Advance the framer by one accepted word and return the result it must produce.
  function automatic frame_res_t parse_byte(input logic [7:0] b, input logic rs);
    frame_res_t      r;
    longint unsigned mag;
    r = '0;
    r.event_res = EvBusy;
    dropped_byte = 1'b0;
    if (rs) begin
      in_array   = 1'b0;
      elems_left = '0;
      prs_phase  = PhAwait;
    end
    case (prs_phase)
      PhAwait: begin
        if (!open_element(b)) begin
          prs_kind    = KindSimple;
          r.event_res = enter_resync();
        end
      end
      PhResync: dropped_byte = !open_element(b);
      PhLine: begin
        if (b == ChCr) prs_phase = PhLineLf;
        else r.content_valid = 1'b1;
      end
      PhLineLf: begin
        if (b == ChLf) r.event_res = close_element();
        else r.event_res = enter_resync();
      end
      PhHdr: begin
        if (b >= ChZero && b <= ChNine) begin
          mag = hdr_mag * 64'd10 + 64'(b - ChZero);
          if (mag > HdrMagMax) begin
            r.event_res = enter_resync();
          end else begin
            hdr_mag   = mag;
            hdr_digit = 1'b1;
          end
        end else if (b == ChMinus && !hdr_digit && !hdr_neg) begin
          hdr_neg = 1'b1;
        end else if (b == ChCr && hdr_digit) begin
          prs_phase = PhHdrLf;
        end else begin
          r.event_res = enter_resync();
        end
      end
      PhHdrLf: begin
        if (b != ChLf) begin
          r.event_res = enter_resync();
        end else if (prs_kind == KindBulk) begin
          if (hdr_neg) begin
            // only "-1" is a null bulk; "-0" and other negatives are refused
            if (hdr_mag == 1) begin
              r.header_done  = 1'b1;
              r.header_value = HdrNull;
              r.event_res    = close_element();
            end else begin
              r.event_res = enter_resync();
            end
          end else if (hdr_mag > longint'(lim_bulk)) begin
            r.event_res = enter_resync();
          end else begin
            r.header_done  = 1'b1;
            r.header_value = HdrValW'(hdr_mag);
            payload_left   = BulkW'(hdr_mag);
            prs_phase      = (payload_left == '0) ? PhTrCr : PhPay;
          end
        end else begin
          if (hdr_neg || hdr_mag == 0) begin
            // negative or zero count: an empty array, complete at once
            r.header_done = 1'b1;
            prs_phase     = PhAwait;
            r.event_res   = EvMsg;
          end else if (hdr_mag > longint'(lim_count)) begin
            r.event_res = enter_resync();
          end else begin
            r.header_done  = 1'b1;
            r.header_value = HdrValW'(hdr_mag);
            in_array       = 1'b1;
            elems_left     = CountW'(hdr_mag);
            prs_phase      = PhAwait;
          end
        end
      end
      PhPay: begin
        r.content_valid = 1'b1;
        payload_left    = payload_left - 1'b1;
        if (payload_left == '0) prs_phase = PhTrCr;
      end
      PhTrCr: begin
        if (trailer_check && b != ChCr) r.event_res = enter_resync();
        else prs_phase = PhTrLf;
      end
      PhTrLf: begin
        if (trailer_check && b != ChLf) r.event_res = enter_resync();
        else r.event_res = close_element();
      end
      default: r.event_res = enter_resync();
    endcase
    r.content_byte = r.content_valid ? b : 8'h00;
    r.element_kind = prs_kind;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field comparison
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (events_due.size() == 0) begin
          $error("result word with nothing expected: event %0d", event_res_o);
          fail_count++;
        end else begin
          want_res = events_due.pop_front();
          check_field("event_res", want_res.event_res, event_res_o);
          check_field("content_valid", want_res.content_valid, content_valid_o);
          check_field("content_byte", want_res.content_byte, content_byte_o);
          check_field("header_done", want_res.header_done, header_done_o);
          check_field("header_value", want_res.header_value, header_value_o);
          check_field("element_kind", want_res.element_kind, element_kind_o);
        end
      end
      // stall with a probability of roughly stall_pct percent
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hard stop for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_resp_frame_parser NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stream side
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then predict its result.
  // Noise may corrupt the byte or raise restart while random traffic runs.
  task automatic send_word(input logic [7:0] b, input logic rs = 1'b0);
    if (noise_pct != 0 && $urandom_range(99) < noise_pct) b = 8'($urandom_range(255));
    if (noise_pct != 0 && $urandom_range(199) < noise_pct) rs = 1'b1;
    rs = rs | restart_next;
    restart_next = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    events_due.insert(events_due.size(), parse_byte(b, rs));
    if (!dropped_byte) counted_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic send_crlf();
    send_word(ChCr);
    send_word(ChLf);
  endtask

  task automatic send_number(input longint unsigned mag);
    send_text($sformatf("%0d", mag));
  endtask

  // Drop valid and wait for every owed result, plus slack for the result register.
  task automatic settle_parser();
    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMaxBulk:  lim_bulk = value[BulkW-1:0];
      CfgMaxCount: lim_count = value[CountW-1:0];
      CfgChkTrail: trailer_check = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CfgDataW-1:0] bulk, input logic [CfgDataW-1:0] count,
                            input logic [CfgDataW-1:0] chk);
    settle_parser();
    write_reg(CfgMaxBulk, bulk);
    write_reg(CfgMaxCount, count);
    write_reg(CfgChkTrail, chk);
  endtask

  // ---------------------------------------------------------------------------
  // Random frame builders
  // ---------------------------------------------------------------------------

  task automatic send_line_element();
    logic [7:0] c;
    int         n;
    case ($urandom_range(2))
      0:       send_word(ChPlus);
      1:       send_word(ChMinus);
      default: send_word(ChColon);
    endcase
    n = $urandom_range(6);
    repeat (n) begin
      // any byte but CR is content, a bare LF included
      do c = 8'($urandom_range(255)); while (c == ChCr);
      send_word(c);
    end
    send_crlf();
  endtask

  task automatic send_bulk_element();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    send_word(ChDollar);
    send_number(len);
    send_crlf();
    repeat (len) send_word(8'($urandom_range(255)));
    send_crlf();
  endtask

  task automatic send_null_bulk();
    send_word(ChDollar);
    send_text("-1");
    send_crlf();
  endtask

  task automatic send_array_element();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) send_line_element();
    else if (pick < 80) send_bulk_element();
    else if (pick < 90) send_null_bulk();
    else if (pick < 93) send_word(ChStar);   // nested array, refused
    else send_line_element();
  endtask

  // Mostly well-formed frames with random content; some noise and overflowing headers.
  task automatic send_random_message();
    int pick;
    int n;
    pick = $urandom_range(99);
    restart_next = ($urandom_range(9) == 0);
    if (pick < 40) begin
      send_line_element();
    end else if (pick < 62) begin
      send_bulk_element();
    end else if (pick < 67) begin
      send_null_bulk();
    end else if (pick < 87) begin
      n = $urandom_range(5);
      send_word(ChStar);
      send_number(n);
      send_crlf();
      repeat (n) send_array_element();
    end else if (pick < 91) begin
      send_word(ChStar);
      send_word(ChMinus);
      send_number($urandom_range(1, 9));
      send_crlf();
    end else if (pick < 94) begin
      send_word($urandom_range(1) ? ChDollar : ChStar);
      repeat (10 + $urandom_range(1)) send_word(ChZero + 8'($urandom_range(9)));
      send_crlf();
    end else begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_line_types();
    send_text("+OK");       send_crlf();
    send_text("-ERR bad");  send_crlf();
    send_text(":-42");      send_crlf();
    send_text("+");         send_crlf();
    // a bare LF inside a line is plain content
    send_text("+a"); send_word(ChLf); send_text("b"); send_crlf();
    send_text(":"); send_word(8'h00); send_word(8'hff); send_crlf();
  endtask

  task automatic test_bulk_strings();
    send_text("$0");  send_crlf(); send_crlf();
    send_text("$03"); send_crlf(); send_text("xyz"); send_crlf();
    // payload may carry CR and LF freely
    send_text("$3");  send_crlf(); send_text("x"); send_crlf(); send_crlf();
    send_text("$-1"); send_crlf();
  endtask

  task automatic test_arrays();
    send_text("*2");  send_crlf();
    send_text("+a");  send_crlf();
    send_text("$1");  send_crlf(); send_text("z"); send_crlf();
    send_text("*0");  send_crlf();
    send_text("*-3"); send_crlf();
    send_text("*1");  send_crlf(); send_text("$-1"); send_crlf();
    // nested array: the inner star errors, the rest is skipped
    send_text("*2");  send_crlf(); send_text(":1"); send_crlf();
    send_text("*1");  send_crlf();
  endtask

  task automatic test_error_recovery();
    send_text("xab");                         // unknown type, then skipped bytes
    send_text("+a"); send_word(ChCr); send_text("b");   // lone CR in a line
    send_word("?", 1'b1);                     // restart on an unknown type byte
    send_text("$1-");                         // minus after a digit
    send_text("$-"); send_word(ChCr);         // CR before any digit
    send_text("$--");                         // second minus
    send_text("$-0"); send_crlf();            // minus zero refused
    send_text("$-2"); send_crlf();            // negative other than minus one
    send_text("$2147483648");                 // magnitude overflow at the last digit
    send_text("$ ");
    send_text("$1"); send_crlf(); send_text("xy");      // bad trailer
    send_text("$2"); send_word(ChCr); send_text("x");   // CR without LF in header
    // restart drops an open array and a partial payload
    send_text("*3"); send_crlf(); send_text("+a"); send_crlf();
    send_word(ChPlus, 1'b1); send_text("b"); send_crlf();
    send_text("$5"); send_crlf(); send_text("ab");
    send_word(ChColon, 1'b1); send_text("7"); send_crlf();
    send_text("*2"); send_crlf(); send_text("x");       // restart during resync next
    send_word(ChPlus, 1'b1); send_crlf();
  endtask

  task automatic test_register_limits();
    set_limits(0, MaxCountRst, 1);
    send_text("$1"); send_crlf();
    send_text("$0"); send_crlf(); send_crlf();
    // largest length accepted; abandon the payload by restart
    set_limits(31'h7fffffff, 0, 1);
    send_text("$2147483647"); send_crlf();
    send_word(ChPlus, 1'b1); send_crlf();
    send_text("*1"); send_crlf();
    send_text("*0"); send_crlf();
    // count register keeps only its low bits
    set_limits(MaxBulkRst, 31'h7fffffff, 31'h7ffffffe);
    send_text("*2097151"); send_crlf();
    send_word(ChPlus, 1'b1); send_crlf();
    send_text("*2097152"); send_crlf();
    // trailer unchecked: two bytes are swallowed, the next one is a type byte
    send_text("$1"); send_crlf(); send_text("abcd");
    settle_parser();
    write_reg(CfgUnused, 31'h5a5a5a5a);
    set_limits(MaxBulkRst, MaxCountRst, 1);
  endtask

  task automatic run_traffic_phase(input logic [CfgDataW-1:0] bulk,
                                   input logic [CfgDataW-1:0] count,
                                   input logic [CfgDataW-1:0] chk,
                                   input int send_idle, input int stall, input int quota);
    set_limits(bulk, count, chk);
    send_idle_pct = send_idle;
    stall_pct     = stall;
    noise_pct     = 3;
    counted_bytes = 0;
    while (counted_bytes < quota) send_random_message();
    noise_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(MaxBulkRst, MaxCountRst, 1, 0, 0, 70);
    run_traffic_phase(5, 3, 0, 53, 0, 70);
    run_traffic_phase(31'h7fffffff, 0, 1, 0, 53, 70);
    run_traffic_phase(8, 4, 1, 20, 20, 70);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_line_types();
    test_bulk_strings();
    test_arrays();
    test_error_recovery();
    test_register_limits();
    test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    settle_parser();
    if (fail_count == 0) begin
      $display("tb_resp_frame_parser OK");
    end else begin
      $display("tb_resp_frame_parser NOT OK");
    end
    $finish;
  end

endmodule
